/* hdl/xssm_pkg.sv */
`timescale 1ns / 1ps

package xssm_pkg;

  localparam int WORDS        = 1024;
  localparam int INDEX_W      = $clog2(WORDS);
  localparam int ADDR_W       = 13;
  localparam int OFFSET_W     = 3;
  localparam int DATA_W       = 64;
  localparam int SHIFT_W      = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] MASK_RESET = 64'h0102_0304_0506_0708;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [1:0] SIZE_1 = 2'd0;
  localparam logic [1:0] SIZE_2 = 2'd1;
  localparam logic [1:0] SIZE_4 = 2'd2;
  localparam logic [1:0] SIZE_8 = 2'd3;

  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      SIZE_1:  m = 64'h0000_0000_0000_00ff;
      SIZE_2:  m = 64'h0000_0000_0000_ffff;
      SIZE_4:  m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

/* hdl/xor_scrambled_subword_memory.sv */
`timescale 1ns / 1ps
// a load goes through the s1 stage and the result register to the result port
// throughput: one word per cycle without stalls; one store read and write per cycle
// stores write back in the cycle after acceptance, forwarded to a following access
// reset: control cleared, scramble mask set to its reset value; word store contents undefined

module xor_scrambled_subword_memory (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [xssm_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              op,
  input  logic [1:0]                        access_size,
  input  logic [xssm_pkg::ADDR_W-1:0]       byte_address,
  input  logic [xssm_pkg::DATA_W-1:0]       write_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [xssm_pkg::DATA_W-1:0]       read_value
);

  logic [xssm_pkg::DATA_W-1:0] word_store [xssm_pkg::WORDS];

  logic [xssm_pkg::DATA_W-1:0] scramble_mask;

  logic                              s1_valid;
  logic                              s1_op;
  logic [1:0]                        s1_size;
  logic [xssm_pkg::INDEX_W-1:0]      s1_index;
  logic [xssm_pkg::OFFSET_W-1:0]     s1_offset;
  logic [xssm_pkg::DATA_W-1:0]       s1_wval;
  logic [xssm_pkg::DATA_W-1:0]       rdata;
  logic [xssm_pkg::DATA_W-1:0]       bypass_word;
  logic                              bypass_hit;

  logic                              s1_advance;
  logic                              accept;
  logic [xssm_pkg::INDEX_W-1:0]      req_index;
  logic [xssm_pkg::DATA_W-1:0]       s1_word;
  logic [xssm_pkg::DATA_W-1:0]       load_value;
  logic [xssm_pkg::DATA_W-1:0]       store_word;
  logic                              s1_store;

  assign req_index  = byte_address[xssm_pkg::OFFSET_W +: xssm_pkg::INDEX_W];
  assign s1_store   = s1_valid && (s1_op == xssm_pkg::OP_STORE);
  assign s1_advance = !s1_valid || s1_store || !rsp_valid || !rsp_stall;
  assign req_stall  = !s1_advance;
  assign accept     = req_valid && s1_advance;
  assign s1_word    = bypass_hit ? bypass_word : rdata;

  xssm_lane u_lane (
    .stored_word (s1_word),
    .mask        (scramble_mask),
    .access_size (s1_size),
    .offset      (s1_offset),
    .write_value (s1_wval),
    .load_value  (load_value),
    .store_word  (store_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_mask <= xssm_pkg::MASK_RESET;
    end else if (cfg_we) begin
      scramble_mask <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_store) begin
      word_store[s1_index] <= store_word;
    end
    if (accept) begin
      rdata <= word_store[req_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      bypass_hit <= 1'b0;
    end else if (accept) begin
      s1_valid   <= 1'b1;
      // the write of the word in flight lands on this same edge
      bypass_hit <= s1_store && (s1_index == req_index);
    end else if (s1_advance) begin
      s1_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op;
      s1_size     <= access_size;
      s1_index    <= req_index;
      s1_offset   <= byte_address[xssm_pkg::OFFSET_W-1:0];
      s1_wval     <= write_value;
      bypass_word <= store_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= s1_valid && (s1_op == xssm_pkg::OP_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      read_value <= load_value;
    end
  end

endmodule

/* hdl/xssm_lane.sv */
`timescale 1ns / 1ps

module xssm_lane (
  input  logic [xssm_pkg::DATA_W-1:0]   stored_word,
  input  logic [xssm_pkg::DATA_W-1:0]   mask,
  input  logic [1:0]                    access_size,
  input  logic [xssm_pkg::OFFSET_W-1:0] offset,
  input  logic [xssm_pkg::DATA_W-1:0]   write_value,
  output logic [xssm_pkg::DATA_W-1:0]   load_value,
  output logic [xssm_pkg::DATA_W-1:0]   store_word
);

  logic [xssm_pkg::DATA_W-1:0]  plain;
  logic [xssm_pkg::DATA_W-1:0]  m;
  logic [xssm_pkg::SHIFT_W-1:0] shift;
  logic [xssm_pkg::DATA_W-1:0]  merged;

  always_comb begin
    plain = stored_word ^ mask;
    m     = xssm_pkg::size_mask(access_size);
    if (access_size == xssm_pkg::SIZE_8) begin
      shift = '0;
    end else begin
      shift = {offset, 3'b000};
    end
    load_value = (plain >> shift) & m;
    // bytes shifted past the top of the word fall away
    if (access_size == xssm_pkg::SIZE_8) begin
      merged = write_value;
    end else begin
      merged = (plain & ~(m << shift)) | ((write_value & m) << shift);
    end
    store_word = merged ^ mask;
  end

endmodule

/* hdl/xssm_checker.sv */
`timescale 1ns / 1ps

module xssm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        op,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [xssm_pkg::DATA_W-1:0] read_value
);

  logic load_accept;

  assign load_accept = req_valid && !req_stall && (op == xssm_pkg::OP_LOAD);

  // a held result word keeps its value
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value))
    else $error("stalled result word changed");

  // input back-pressure only comes from a full, stalled result port
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without result back-pressure");

  // every accepted load reaches the result port through the s1 stage and the result register
  assert property (@(posedge clk) disable iff (rst)
    load_accept |-> ##2 rsp_valid)
    else $error("load word did not reach the result port");

  // a fresh result word needs an accepted load that came through the s1 stage and the result register
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(load_accept, 2))
    else $error("result word without a load");

endmodule

bind xor_scrambled_subword_memory xssm_checker u_xssm_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .op         (op),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .read_value (read_value)
);

/* tb/xssm_access_checker.sv */
`timescale 1ns / 1ps

module xssm_access_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [xssm_pkg::DATA_W-1:0] cfg_wdata,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic                        op,
  input  logic [1:0]                  access_size,
  input  logic [xssm_pkg::ADDR_W-1:0] byte_address,
  input  logic [xssm_pkg::DATA_W-1:0] write_value,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic [xssm_pkg::DATA_W-1:0] read_value,
  output int                          load_words_due,
  output int                          mismatch_count
);
  import xssm_pkg::*;

  logic [DATA_W-1:0] scrambled_words [WORDS];
  logic [DATA_W-1:0] scramble_key;
  logic [DATA_W-1:0] load_due [$];

  initial begin
    load_words_due = 0;
    mismatch_count = 0;
    scramble_key   = MASK_RESET;
    foreach (scrambled_words[i]) scrambled_words[i] = '0;
  end

  function automatic logic [DATA_W-1:0] lane_mask(input logic [1:0] size);
    if (size == SIZE_8) return '1;
    return (64'd1 << (8 << size)) - 64'd1;
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : predict
    logic [DATA_W-1:0] plain;
    logic [DATA_W-1:0] lanes;
    logic [DATA_W-1:0] want;
    int                word_index;
    int                shift;
    if (rst) begin
      scramble_key = MASK_RESET;
      load_due.delete();
    end else begin
      if (cfg_we) scramble_key = cfg_wdata;
      if (rsp_valid && !rsp_stall) begin
        if (load_due.size() == 0) begin
          report("read_value (load word with nothing expected)", read_value, '0);
        end else begin
          want = load_due.pop_front();
          if (read_value !== want) report("read_value", read_value, want);
        end
      end
      if (req_valid && !req_stall) begin
        word_index = int'(byte_address[ADDR_W-1:OFFSET_W]) % WORDS;
        shift      = (access_size == SIZE_8) ? 0 : 8 * int'(byte_address[OFFSET_W-1:0]);
        lanes      = lane_mask(access_size);
        plain      = scrambled_words[word_index] ^ scramble_key;
        if (op == OP_LOAD) begin
          load_due.push_back((plain >> shift) & lanes);
        end else if (access_size == SIZE_8) begin
          scrambled_words[word_index] = write_value ^ scramble_key;
        end else begin
          plain = (plain & ~(lanes << shift)) | ((write_value & lanes) << shift);
          scrambled_words[word_index] = plain ^ scramble_key;
        end
      end
    end
    load_words_due = load_due.size();
  end

endmodule

/* tb/xor_scrambled_subword_memory_tb.sv */
`timescale 1ns / 1ps

module xor_scrambled_subword_memory_tb;
  import xssm_pkg::*;

  localparam int CYCLE_LIMIT     = 800000;
  localparam int PHASE_WORDS     = 385;
  localparam int HOLD_AT         = 700;
  localparam int HOLD_OFF_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [DATA_W-1:0] cfg_wdata;
  logic              req_valid;
  logic              req_stall;
  logic              op;
  logic [1:0]        access_size;
  logic [ADDR_W-1:0] byte_address;
  logic [DATA_W-1:0] write_value;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [DATA_W-1:0] read_value;

  int load_words_due;
  int mismatch_count;

  int cycle_count = 0;
  int words_sent  = 0;
  int last_index  = 0;
  bit hold_done   = 1'b0;
  bit calm        = 1'b0;
  bit word_written [WORDS];
  int written_list [$];

  xor_scrambled_subword_memory u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .op           (op),
    .access_size  (access_size),
    .byte_address (byte_address),
    .write_value  (write_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .read_value   (read_value)
  );

  xssm_access_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .op             (op),
    .access_size    (access_size),
    .byte_address   (byte_address),
    .write_value    (write_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .read_value     (read_value),
    .load_words_due (load_words_due),
    .mismatch_count (mismatch_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** xor_scrambled_subword_memory: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    rsp_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AT) begin
        rsp_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        rsp_stall = 1'b0;
        free_left--;
      end else begin
        rsp_stall  = 1'b0;
        free_left  = $urandom_range(0, 8);
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input logic o_code, input logic [1:0] size,
                           input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    int gap;
    int index;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid    = 1'b1;
    op           = o_code;
    access_size  = size;
    byte_address = addr;
    write_value  = value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
    index = int'(addr >> OFFSET_W);
    if (o_code == OP_STORE && size == SIZE_8 && !word_written[index]) begin
      word_written[index] = 1'b1;
      written_list.push_back(index);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid = 1'b0;
    while (load_words_due != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_mask(input logic [DATA_W-1:0] value);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // narrow accesses and loads only ever touch words already written whole
  task automatic random_word();
    logic              o_code;
    logic [1:0]        size;
    logic [ADDR_W-1:0] addr;
    int                index;
    o_code = 1'($urandom_range(0, 1));
    size   = 2'($urandom_range(0, 3));
    if (o_code == OP_STORE && size == SIZE_8 && $urandom_range(0, 3) == 0) begin
      addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    end else begin
      if ($urandom_range(0, 1) == 0) index = last_index;
      else index = written_list[$urandom_range(0, written_list.size() - 1)];
      addr = ADDR_W'(index * 8 + $urandom_range(0, 7));
    end
    send_word(o_code, size, addr, pick_value());
    last_index = int'(addr >> OFFSET_W);
  endtask

  initial begin
    logic [DATA_W-1:0] mask_plan [5];
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_valid    = 1'b0;
    op           = OP_LOAD;
    access_size  = SIZE_1;
    byte_address = '0;
    write_value  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    send_word(OP_STORE, SIZE_8, 13'h0000, 64'h0123_4567_89ab_cdef);
    send_word(OP_STORE, SIZE_8, 13'h1fff, '1);
    send_word(OP_STORE, SIZE_8, 13'h000d, '0);
    send_word(OP_LOAD,  SIZE_8, 13'h0005, '0);
    send_word(OP_LOAD,  SIZE_8, 13'h1ff8, '0);
    send_word(OP_LOAD,  SIZE_1, 13'h0000, '0);
    send_word(OP_LOAD,  SIZE_1, 13'h0007, '0);
    send_word(OP_LOAD,  SIZE_2, 13'h0003, '0);
    send_word(OP_LOAD,  SIZE_2, 13'h0007, '0);
    send_word(OP_LOAD,  SIZE_4, 13'h0004, '0);
    send_word(OP_LOAD,  SIZE_4, 13'h0006, '0);
    send_word(OP_LOAD,  SIZE_1, 13'h1fff, '0);
    send_word(OP_STORE, SIZE_1, 13'h0002, 64'hffff_ffff_ffff_ffa5);
    // straddles the word end: the neighbour must stay untouched
    send_word(OP_STORE, SIZE_2, 13'h0007, '1);
    send_word(OP_LOAD,  SIZE_8, 13'h0008, '0);
    send_word(OP_STORE, SIZE_4, 13'h000e, 64'h89ab_cdef_dead_beef);
    send_word(OP_STORE, SIZE_2, 13'h0009, '0);
    send_word(OP_LOAD,  SIZE_8, 13'h0008, '0);
    send_word(OP_LOAD,  SIZE_8, 13'h0000, '0);
    send_word(OP_STORE, SIZE_4, 13'h1ffc, '0);
    send_word(OP_LOAD,  SIZE_4, 13'h1ffc, '0);
    send_word(OP_LOAD,  SIZE_8, 13'h1ff9, '0);

    // old scrambled bits read back under a new mask
    write_mask('0);
    send_word(OP_LOAD, SIZE_8, 13'h0000, '0);
    send_word(OP_LOAD, SIZE_8, 13'h0008, '0);
    send_word(OP_LOAD, SIZE_8, 13'h1ff8, '0);

    mask_plan[0] = '1;
    mask_plan[1] = {$urandom, $urandom};
    mask_plan[2] = 64'h8000_0000_0000_0001;
    mask_plan[3] = {$urandom, $urandom};
    mask_plan[4] = MASK_RESET;
    foreach (mask_plan[p]) begin
      write_mask(mask_plan[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        calm = ((i / 64) % 4) == 3;
        random_word();
      end
      calm = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** xor_scrambled_subword_memory: PASSED **");
    end else begin
      $display("** xor_scrambled_subword_memory: FAILED **");
    end
    $finish;
  end

endmodule
